### sv/iqu_pkg.sv
// ============================================================================
// iqu_pkg: shared types and constants of the quantile update unit
// Register indexes, step sequencer types and the exp2 root table.
// ============================================================================
`default_nettype none

package iqu_pkg;

   // Configuration register indexes.
   localparam int CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_ALPHA = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_NMAX  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_LEN   = 2'd2;

   // Fixed-point constants of the gamma schedule: 9 * 65536 and 0.1 * 65536.
   localparam logic [19:0] GAMMA_SCALE  = 20'd589824;
   localparam logic [15:0] GAMMA_OFFSET = 16'd6554;
   localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

   // Step sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_LOG,
      ST_MUL,
      ST_EXP,
      ST_SHIFT
   } step_state_type;

   // Control from the element pipeline to the step sequencer.
   typedef struct packed {
      logic        start;
      logic        clear;
      logic [15:0] n;
      logic [15:0] nmax;
   } step_ctl_type;

   // Status returned by the step sequencer.
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] step;
   } step_sts_type;

   typedef logic [16:0][31:0] exp_tbl_type;

   // Integer square root of a 64-bit value, evaluated at elaboration only.
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] rem;
      logic [63:0] res;
      logic [63:0] bitv;
      rem  = v;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Root table: entry k holds 2^32 * 2^(-2^-k), entry 0 holds 2^31.
   function automatic exp_tbl_type make_exp_tbl();
      exp_tbl_type tbl;
      logic [63:0] t;
      t = 64'd1 << 31;
      tbl[0] = t[31:0];
      for (int k = 1; k <= 16; k++) begin
         t = isqrt64(t << 32);
         tbl[k] = t[31:0];
      end
      return tbl;
   endfunction

   localparam exp_tbl_type EXP_TBL = make_exp_tbl();

endpackage

`default_nettype wire

### sv/iqu_ram.sv
// ============================================================================
// iqu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; a read of an address written
// at the same edge returns the old data.
// ============================================================================
`default_nettype none

module iqu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### sv/iqu_step.sv
// ============================================================================
// iqu_step: step size sequencer
// Works out 1/n^gamma in Q0.32 with a bit-serial divider for gamma, a
// squaring loop for log2(n) and a table-driven multiply loop for exp2.
// ============================================================================
`default_nettype none

module iqu_step (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire iqu_pkg::step_ctl_type ctl,
   output iqu_pkg::step_sts_type     sts
);
   import iqu_pkg::*;

   step_state_type state_ff, state_in;
   logic [15:0] n_ff, n_in;
   logic [19:0] den_ff, den_in;
   logic [35:0] num_ff, num_in;
   logic [19:0] rem_ff, rem_in;
   logic [35:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [30:0] x_ff, x_in;
   logic [15:0] frac_ff, frac_in;
   logic [3:0]  msb_ff, msb_in;
   logic [31:0] gamma_ff, gamma_in;
   logic [35:0] e_ff, e_in;
   logic [32:0] r_ff, r_in;
   logic [31:0] result_ff, result_in;
   logic        done_ff, done_in;

   logic [15:0] nmax_eff;
   logic [3:0]  msb_now;
   logic [45:0] x_norm;
   logic [20:0] rem_sh;
   logic [61:0] sq;
   logic [31:0] sq_top;
   logic [36:0] gamma_sum;
   logic [51:0] e_prod;
   logic [64:0] r_prod;
   logic [4:0]  kidx;
   logic [32:0] r_shift;

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff      <= n_in;
      den_ff    <= den_in;
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      x_ff      <= x_in;
      frac_ff   <= frac_in;
      msb_ff    <= msb_in;
      gamma_ff  <= gamma_in;
      e_ff      <= e_in;
      r_ff      <= r_in;
      result_ff <= result_in;
   end

   // Next state and datapath.
   always_comb begin
      state_in  = state_ff;
      done_in   = done_ff;
      n_in      = n_ff;
      den_in    = den_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      x_in      = x_ff;
      frac_in   = frac_ff;
      msb_in    = msb_ff;
      gamma_in  = gamma_ff;
      e_in      = e_ff;
      r_in      = r_ff;
      result_in = result_ff;

      nmax_eff = (ctl.nmax < 16'd2) ? 16'd2 : ctl.nmax;

      // Leading one of n.
      msb_now = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (n_ff[i]) begin
            msb_now = 4'(i);
         end
      end
      x_norm = {n_ff, 30'd0} >> msb_now;

      rem_sh    = {rem_ff, num_ff[35]};
      sq        = 62'(x_ff) * 62'(x_ff);
      sq_top    = sq[61:30];
      gamma_sum = 37'(quo_ff) + 37'(GAMMA_OFFSET);
      e_prod    = 52'(gamma_ff) * 52'({msb_ff, frac_ff});
      kidx      = 5'(cnt_ff) + 5'd1;
      r_prod    = 65'(r_ff) * 65'(EXP_TBL[kidx]);
      r_shift   = r_ff >> e_ff[20:16];

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start && !ctl.clear) begin
               n_in     = ctl.n;
               den_in   = 20'(20'(nmax_eff - 16'd1) * 20'd10);
               done_in  = 1'b0;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            num_in   = 36'(36'(n_ff - 16'd1) * 36'(GAMMA_SCALE)) + 36'(den_ff >> 1);
            msb_in   = msb_now;
            x_in     = x_norm[30:0];
            frac_in  = 16'd0;
            rem_in   = 20'd0;
            quo_in   = 36'd0;
            cnt_in   = 6'd0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // One quotient bit per cycle.
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = 20'(rem_sh - {1'b0, den_ff});
               quo_in = {quo_ff[34:0], 1'b1};
            end else begin
               rem_in = rem_sh[19:0];
               quo_in = {quo_ff[34:0], 1'b0};
            end
            num_in = {num_ff[34:0], 1'b0};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd35) begin
               cnt_in   = 6'd0;
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            // Gamma saturates at 32 bits; any larger value already gives a zero step.
            gamma_in = (gamma_sum[36:32] != 5'd0) ? 32'hFFFF_FFFF : gamma_sum[31:0];
            // One fraction bit of log2 per squaring.
            if (sq_top[31]) begin
               x_in    = sq_top[31:1];
               frac_in = {frac_ff[14:0], 1'b1};
            end else begin
               x_in    = sq_top[30:0];
               frac_in = {frac_ff[14:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) begin
               cnt_in   = 6'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            e_in     = e_prod[51:16];
            r_in     = 33'h1_0000_0000;
            cnt_in   = 6'd0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            // One fraction bit of the exponent per cycle, most significant first.
            if (e_ff[5'd15 - 5'(cnt_ff)]) begin
               r_in = r_prod[64:32];
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd15) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (e_ff[35:21] != 15'd0) begin
               result_in = 32'd0;
            end else if (r_shift[32]) begin
               result_in = 32'hFFFF_FFFF;
            end else begin
               result_in = r_shift[31:0];
            end
            done_in  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ctl.clear) begin
         state_in = ST_IDLE;
         done_in  = 1'b0;
      end
   end

   assign sts.busy = (state_ff != ST_IDLE);
   assign sts.done = done_ff;
   assign sts.step = result_ff;

   // A finished result and a running computation never coexist.
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      !(sts.busy && sts.done))
      else $error("step sequencer busy while done");

endmodule

`default_nettype wire

### sv/iterative_quantile_update_unit.sv
// ============================================================================
// iterative_quantile_update_unit: running quantile estimate per vector element
// Robbins-Monro update of one estimate per position, kept in a RAM, with the
// step size worked out once per vector by a sequential step unit.
// ============================================================================
//
//   Channel | Ports                              | Direction
//   --------+------------------------------------+-----------
//   req     | req_valid/ready, req_sample        | in
//   rsp     | rsp_valid/ready, rsp_estimate,     | out
//           | rsp_element_index, rsp_last_of_... |
//   csr     | csr_valid/ready, csr_index/data    | in
//
// Elements transfer one per cycle inside a vector while the output is not stalled; a result
// is presented once its element has passed the RAM read and the update into the output register.
// The first element of every vector after the first waits while the step unit runs its setup,
// divider, log2 squaring loop, product, exp2 multiply loop and final shift; once the count
// saturates there is no wait. Reset clears count, position and step; the estimate RAM is not cleared.
// A stalled output holds the update stage, which holds the input.
`default_nettype none

module iterative_quantile_update_unit #(
   parameter int VECTOR_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [31:0]            req_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [31:0]                 rsp_estimate,
   output logic [9:0]                         rsp_element_index,
   output logic                               rsp_last_of_vector,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [iqu_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [15:0]                   csr_data
);
   import iqu_pkg::*;

   localparam int AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
   localparam logic [16:0] DEPTH17 = 17'(VECTOR_DEPTH);

   // Configuration registers.
   logic [15:0] alpha_ff;
   logic [15:0] nmax_ff;
   logic [10:0] len_ff;

   // Vector control state.
   logic [15:0]   cnt_ff, cnt_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [31:0]   step_ff, step_in;

   // Update stage.
   logic               s1_valid_ff;
   logic signed [31:0] s1_smp_ff;
   logic [AW-1:0]      s1_pos_ff;
   logic               s1_last_ff;
   logic               s1_first_ff;
   logic [16:0]        s1_dn_ff, s1_up_ff;

   // Last RAM write, for forwarding.
   logic               fwd_valid_ff;
   logic [AW-1:0]      fwd_addr_ff;
   logic signed [31:0] fwd_data_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_est_ff;
   logic [9:0]         rsp_idx_ff;
   logic               rsp_last_ff;

   step_ctl_type step_ctl;
   step_sts_type step_sts;

   logic               req_fire, csr_fire, s1_go, s1_free;
   logic               need_step, upd;
   logic [15:0]        cnt_new;
   logic [31:0]        step_use;
   logic [16:0]        len_eff, pos_next17;
   logic               last;
   logic [16:0]        w_dn;
   logic [48:0]        dn_prod, up_prod;
   logic [31:0]        ram_rd;
   logic signed [31:0] est_old, est_new;
   logic signed [32:0] est_sum;
   logic [16:0]        s1_idx17;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;
   assign req_fire  = req_valid && req_ready;

   // Configuration write decode.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= 16'd32768;
         nmax_ff  <= 16'd1000;
         len_ff   <= 11'd1024;
      end else if (csr_fire) begin
         unique case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_data;
            CSR_NMAX:  nmax_ff  <= csr_data;
            CSR_LEN:   len_ff   <= csr_data[10:0];
            default: begin
            end
         endcase
      end
   end

   // A new step is needed at the head of every vector after the first until the count saturates.
   assign upd       = (pos_ff == '0) && (cnt_ff != COUNT_MAX);
   assign need_step = upd && (cnt_ff != 16'd0);

   assign step_ctl.start = need_step && req_valid && !step_sts.busy && !step_sts.done;
   assign step_ctl.clear = req_fire || csr_fire;
   assign step_ctl.n     = cnt_ff + 16'd1;
   assign step_ctl.nmax  = nmax_ff;

   iqu_step u_step (
      .clock (clock),
      .reset (reset),
      .ctl   (step_ctl),
      .sts   (step_sts)
   );

   // Handshake of the update stage and the output register.
   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s1_free   = !s1_valid_ff || s1_go;
   assign req_ready = s1_free && (!need_step || step_sts.done);

   // Accept-side arithmetic: count, step, position and both step deltas.
   always_comb begin
      cnt_new  = upd ? (cnt_ff + 16'd1) : cnt_ff;
      step_use = step_ff;
      if (upd) begin
         step_use = (cnt_ff == 16'd0) ? 32'd0 : step_sts.step;
      end
      len_eff = 17'(len_ff);
      if (len_eff == 17'd0) begin
         len_eff = 17'd1;
      end
      if (len_eff > DEPTH17) begin
         len_eff = DEPTH17;
      end
      pos_next17 = 17'(pos_ff) + 17'd1;
      last       = (pos_next17 >= len_eff);
      w_dn       = 17'h1_0000 - {1'b0, alpha_ff};
      dn_prod    = 49'(w_dn) * 49'(step_use) + 49'h0_8000_0000;
      up_prod    = 49'(alpha_ff) * 49'(step_use) + 49'h0_8000_0000;
      cnt_in     = req_fire ? cnt_new : cnt_ff;
      step_in    = req_fire ? step_use : step_ff;
      pos_in     = pos_ff;
      if (req_fire) begin
         pos_in = last ? '0 : pos_next17[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 16'd0;
         pos_ff  <= '0;
         step_ff <= 32'd0;
      end else begin
         cnt_ff  <= cnt_in;
         pos_ff  <= pos_in;
         step_ff <= step_in;
      end
   end

   // Estimate memory: read at transfer, written back by the update stage.
   iqu_ram #(
      .WIDTH (32),
      .DEPTH (VECTOR_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_pos_ff),
      .wr_data (est_new),
      .rd_en   (req_fire),
      .rd_addr (pos_ff),
      .rd_data (ram_rd)
   );

   // Update stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         s1_smp_ff   <= req_sample;
         s1_pos_ff   <= pos_ff;
         s1_last_ff  <= last;
         s1_first_ff <= (cnt_new <= 16'd1);
         s1_dn_ff    <= dn_prod[48:32];
         s1_up_ff    <= up_prod[48:32];
      end
   end

   // Compare, step and saturate; in the first vector the sample itself becomes the estimate.
   always_comb begin
      est_old = (fwd_valid_ff && (fwd_addr_ff == s1_pos_ff)) ? fwd_data_ff : $signed(ram_rd);
      est_sum = 33'sd0;
      if (est_old >= s1_smp_ff) begin
         est_sum = 33'(est_old) - $signed({16'd0, s1_dn_ff});
      end else begin
         est_sum = 33'(est_old) + $signed({16'd0, s1_up_ff});
      end
      if (s1_first_ff) begin
         est_new = s1_smp_ff;
      end else if (est_sum > 33'sd2147483647) begin
         est_new = 32'sh7FFF_FFFF;
      end else if (est_sum < -33'sd2147483648) begin
         est_new = 32'sh8000_0000;
      end else begin
         est_new = est_sum[31:0];
      end
      s1_idx17 = 17'(s1_pos_ff);
   end

   // Forwarding register and output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_go) begin
            fwd_valid_ff <= 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (s1_go) begin
         fwd_addr_ff <= s1_pos_ff;
         fwd_data_ff <= est_new;
         rsp_est_ff  <= est_new;
         rsp_idx_ff  <= s1_idx17[9:0];
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_estimate       = rsp_est_ff;
   assign rsp_element_index  = rsp_idx_ff;
   assign rsp_last_of_vector = rsp_last_ff;

   // The head of a vector is taken only with a finished step.
   a_step_ready: assert property (@(posedge clock) disable iff (reset)
      req_fire && need_step |-> step_sts.done)
      else $error("vector head taken without a step");

   // The count rises by one at each vector head until it saturates.
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      req_fire && upd |=> cnt_ff == $past(cnt_ff) + 16'd1)
      else $error("sample count did not advance");

   // The position stays inside the memory.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      17'(pos_ff) < DEPTH17)
      else $error("position beyond memory depth");

   // A moving update stage always fills the output register.
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      s1_go |=> rsp_valid && fwd_valid_ff)
      else $error("update lost on its way out");

endmodule

`default_nettype wire
